// ===== hdl/cklex_pkg.sv =====
// Package for the command keyword lexer: token kinds, separator codes,
// counter limits, the keyword table and the keyword match function.
// No dependencies.
`default_nettype none

package cklex_pkg;

    localparam int MAX_KEYWORD_CHARS = 10;
    localparam int MAX_LINE_CHARS    = 4096;

    localparam int CNT_W    = 12;
    localparam int KIND_W   = 5;
    localparam int WC_IDX_W = $clog2(MAX_KEYWORD_CHARS);

    // Position and length counters stop here.
    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_LINE_CHARS - 1 < 4095) ? (MAX_LINE_CHARS - 1) : 4095);

    localparam logic [KIND_W-1:0] KIND_LITERAL = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd21;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd22;
    localparam logic [KIND_W-1:0] KIND_QUOTE   = 5'd23;
    localparam logic [KIND_W-1:0] KIND_END     = 5'd24;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    // Keywords are held as ten-character strings padded with spaces, so
    // character i of every entry sits in byte (KW_TEXT_CHARS-1-i).
    localparam int NUM_KEYWORDS  = 20;
    localparam int KW_TEXT_CHARS = 10;

    localparam logic [8*KW_TEXT_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "INSERT    ", "DELETE    ", "CREATE    ", "INTO      ",
        "FROM      ", "TABLE     ", "UPDATE    ", "SHOW      ",
        "OPEN      ", "CLOSE     ", "WRITE     ", "EXIT      ",
        "SELECT    ", "PROJECT   ", "RENAME    ", "SET       ",
        "CROSS     ", "UNION     ", "DIFFERENCE", "PRODUCT   "
    };

    localparam int KW_LEN [NUM_KEYWORDS] = '{
        6, 6, 6, 4, 4, 5, 6, 4, 4, 5, 5, 4, 6, 7, 6, 3, 5, 5, 10, 7
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  start;
        logic [CNT_W-1:0]  length;
        logic              eoc;
    } token_t;

    // Exact, case-sensitive match of a finished word against the table.
    // Only the first len characters are compared, so unwritten bytes
    // never matter.
    function automatic logic [KIND_W-1:0] kw_classify(
        input logic [7:0]       chars [MAX_KEYWORD_CHARS],
        input logic [CNT_W-1:0] len
    );
        logic [KIND_W-1:0] kind;
        logic              same;
        kind = KIND_LITERAL;
        if (len <= CNT_W'(MAX_KEYWORD_CHARS))
        begin
            for (int k = 0; k < NUM_KEYWORDS; k++)
            begin
                same = (len == CNT_W'(KW_LEN[k]));
                for (int i = 0; i < KW_TEXT_CHARS; i++)
                begin
                    if ((CNT_W'(i) < len) &&
                        (chars[i] != KW_TEXT[k][8*(KW_TEXT_CHARS-1-i) +: 8]))
                    begin
                        same = 1'b0;
                    end
                end
                if (same && (kind == KIND_LITERAL))
                begin
                    kind = KIND_W'(k + 1);
                end
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/command_keyword_lexer_core.sv =====
// Top level of the command keyword lexer: word collection, keyword match
// and a four-entry token queue. Depends on cklex_pkg.
`default_nettype none

// Usage
// The input stream carries one character byte per request on s_axis_tdata.
// A request with s_axis_tlast high marks the end of the command line; its
// byte is ignored. Spaces end the current word; '(' , ')' and '"' end it and
// give a one-character token of their own. A finished word is matched
// against twenty keywords or reported as a literal.
// The output stream carries one token per request: m_axis_tuser is its
// kind, m_axis_tdata its start position and length, and m_axis_tlast marks
// the end-of-command token that closes each line.
// A token enters the queue when the character finishing it is taken.
// Throughput: one character per cycle while the queue has room. A character
// may give two tokens (a pending word and a separator token); both are
// written into the queue in the same cycle, and the queue drains one per
// cycle while m_axis_tready is high. s_axis_tready is high while the queue
// has room for two tokens, so a stalled receiver holds the input back once
// three or more tokens wait. Reset empties the queue and clears the word
// length, word start and line position; the stored word bytes need no reset.
module command_keyword_lexer_core
    import cklex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_axis_tdata: [7:0] char_code
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,   // line_end
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // m_axis_tdata: [11:0] token_start, [23:12] token_length
    output logic [23:0]      m_axis_tdata,
    // m_axis_tuser: [4:0] token_kind
    output logic [4:0]       m_axis_tuser,
    output logic             m_axis_tlast,   // end_of_command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Word and line state.
    logic [7:0]       word_chars_reg [MAX_KEYWORD_CHARS];
    logic [CNT_W-1:0] word_length_reg, word_length_next;
    logic [CNT_W-1:0] word_start_reg, word_start_next;
    logic [CNT_W-1:0] line_pos_reg, line_pos_next;

    // Token queue.
    token_t              queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    logic       in_fire;
    logic       out_fire;
    logic       is_space;
    logic       is_symbol;
    logic       flush;
    logic       has_word;
    logic [1:0] push_cnt;
    token_t     word_tok;
    token_t     second_tok;
    token_t     push0;
    token_t     push1;
    logic       second_valid;
    logic [KIND_W-1:0] sym_kind;
    logic [CNT_W-1:0]  pos_adv;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Room for two tokens is needed before a character is taken.
    assign s_axis_tready = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb
    begin
        is_space  = !s_axis_tlast && (s_axis_tdata == CH_SPACE);
        is_symbol = !s_axis_tlast &&
                    ((s_axis_tdata == CH_LPAREN) || (s_axis_tdata == CH_RPAREN) ||
                     (s_axis_tdata == CH_QUOTE));
        flush     = s_axis_tlast || is_space || is_symbol;
        has_word  = (word_length_reg != '0);

        case (s_axis_tdata)
            CH_LPAREN: sym_kind = KIND_LPAREN;
            CH_RPAREN: sym_kind = KIND_RPAREN;
            default:   sym_kind = KIND_QUOTE;
        endcase

        pos_adv = (line_pos_reg < COUNT_CAP) ? (line_pos_reg + CNT_W'(1)) : line_pos_reg;

        word_tok.kind   = kw_classify(word_chars_reg, word_length_reg);
        word_tok.start  = word_start_reg;
        word_tok.length = word_length_reg;
        word_tok.eoc    = 1'b0;

        // The separator or end-of-command token that may follow the word.
        second_valid = s_axis_tlast || is_symbol;
        if (s_axis_tlast)
        begin
            second_tok.kind   = KIND_END;
            second_tok.start  = line_pos_reg;
            second_tok.length = '0;
            second_tok.eoc    = 1'b1;
        end
        else
        begin
            second_tok.kind   = sym_kind;
            second_tok.start  = line_pos_reg;
            second_tok.length = CNT_W'(1);
            second_tok.eoc    = 1'b0;
        end

        // Pack the tokens of this character so that the queue sees no gap.
        push_cnt = 2'd0;
        push0    = second_tok;
        push1    = second_tok;
        if (in_fire && flush)
        begin
            if (has_word)
            begin
                push0    = word_tok;
                push_cnt = second_valid ? 2'd2 : 2'd1;
            end
            else
            begin
                push_cnt = second_valid ? 2'd1 : 2'd0;
            end
        end

        word_length_next = word_length_reg;
        word_start_next  = word_start_reg;
        line_pos_next    = line_pos_reg;
        if (in_fire)
        begin
            if (s_axis_tlast)
            begin
                word_length_next = '0;
                word_start_next  = '0;
                line_pos_next    = '0;
            end
            else if (flush)
            begin
                word_length_next = '0;
                line_pos_next    = pos_adv;
            end
            else
            begin
                if (!has_word)
                begin
                    word_start_next = line_pos_reg;
                end
                if (word_length_reg < COUNT_CAP)
                begin
                    word_length_next = word_length_reg + CNT_W'(1);
                end
                line_pos_next = pos_adv;
            end
        end

        count_next = count_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= '0;
            word_start_reg  <= '0;
            line_pos_reg    <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            word_length_reg <= word_length_next;
            word_start_reg  <= word_start_next;
            line_pos_reg    <= line_pos_next;
            wr_ptr_reg      <= wr_ptr_reg + Q_PTR_W'(push_cnt);
            rd_ptr_reg      <= rd_ptr_reg + Q_PTR_W'(out_fire);
            count_reg       <= count_next;
        end
    end

    // Word bytes: only the first MAX_KEYWORD_CHARS of a word are kept.
    always_ff @(posedge clk)
    begin
        if (in_fire && !flush && (word_length_reg < CNT_W'(MAX_KEYWORD_CHARS)))
        begin
            word_chars_reg[word_length_reg[WC_IDX_W-1:0]] <= s_axis_tdata;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + Q_PTR_W'(1)] <= push1;
        end
    end

    always_comb
    begin
        m_axis_tvalid = (count_reg != '0);
        m_axis_tuser  = queue_reg[rd_ptr_reg].kind;
        m_axis_tdata  = {queue_reg[rd_ptr_reg].length, queue_reg[rd_ptr_reg].start};
        m_axis_tlast  = queue_reg[rd_ptr_reg].eoc;
    end

endmodule

`default_nettype wire
